[hdl/tlr_pkg.sv]
// Shared constants, codes and controller/datapath structs for the thick line rasterizer.
// No dependencies; every other file of the block but tlr_divider uses this package.
package tlr_pkg;

  localparam int COORD_BITS_DEF  = 12;
  localparam int FRAME_WIDTH_DEF = 320;

  localparam int SIZE_BITS  = 6;
  localparam int COLOR_BITS = 8;
  localparam int ADDR_BITS  = 32;
  localparam int DISC_BITS  = 7;   // signed brush offset, -64..63
  localparam int THR_SHIFT  = 2;   // radius squared is size squared over 4

  localparam int APB_DATA_BITS = 32;
  localparam int APB_ADDR_BITS = 3;  // msb selects the register index

  localparam logic [ADDR_BITS-1:0] FRAME_BASE_RST = 32'h000A_0000;

  // register index, taken from the top bit of paddr
  localparam logic REG_FRAME_BASE = 1'b0;

  localparam logic MODE_START = 1'b0;
  localparam logic MODE_STEP  = 1'b1;

  localparam logic KIND_PIXEL = 1'b0;
  localparam logic KIND_DONE  = 1'b1;

  typedef struct packed {
    logic take_in;
    logic latch;
    logic setup;
    logic mul;
    logic div_go;
    logic place;
    logic step_major;
    logic next_row;
    logic next_col;
    logic finish;
    logic load_out;
  } tlr_cmd_t;

  typedef struct packed {
    logic in_valid;
    logic in_mode;
    logic busy;
    logic at_end;
    logic i_done;
    logic j_done;
    logic in_disc;
    logic div_running;
    logic out_free;
  } tlr_sts_t;

endpackage

[hdl/tlr_in_if.sv]
// Command channel of the thick line rasterizer: valid/ready plus one command word.
// Depends on tlr_pkg for field widths.
interface tlr_in_if #(
  parameter int COORD_BITS = tlr_pkg::COORD_BITS_DEF
) ();
  logic                              valid;
  logic                              ready;
  logic                              mode;
  logic signed [COORD_BITS-1:0]      x_start;
  logic signed [COORD_BITS-1:0]      y_start;
  logic signed [COORD_BITS-1:0]      x_end;
  logic signed [COORD_BITS-1:0]      y_end;
  logic [tlr_pkg::SIZE_BITS-1:0]     brush_size;
  logic [tlr_pkg::COLOR_BITS-1:0]    pen_color;

  modport source (
    output valid, mode, x_start, y_start, x_end, y_end, brush_size, pen_color,
    input  ready
  );
  modport sink (
    input  valid, mode, x_start, y_start, x_end, y_end, brush_size, pen_color,
    output ready
  );
endinterface

[hdl/tlr_out_if.sv]
// Result channel of the thick line rasterizer: valid/ready plus one pixel-write word.
// Depends on tlr_pkg for field widths.
interface tlr_out_if ();
  logic                           valid;
  logic                           ready;
  logic                           kind;
  logic [tlr_pkg::ADDR_BITS-1:0]  address;
  logic [tlr_pkg::COLOR_BITS-1:0] pixel_color;

  modport source (output valid, kind, address, pixel_color, input ready);
  modport sink   (input  valid, kind, address, pixel_color, output ready);
endinterface

[hdl/tlr_divider.sv]
// Radix-2 restoring signed divider, quotient truncated toward zero, one bit per cycle.
// Depends on nothing beyond the clock and reset.
module tlr_divider #(
  parameter int NUM_BITS = 26,
  parameter int DEN_BITS = 13
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  input  logic signed [NUM_BITS-1:0] numer,
  input  logic signed [DEN_BITS-1:0] denom,
  output logic                       running,
  output logic signed [NUM_BITS-1:0] quot
);
  localparam int CNT_BITS = $clog2(NUM_BITS + 1);

  logic [NUM_BITS-1:0] numer_u;
  logic [DEN_BITS-1:0] denom_u;
  logic [NUM_BITS-1:0] nmag;
  logic [DEN_BITS-1:0] dmag_in;
  logic [NUM_BITS-1:0] quo;
  logic [DEN_BITS-1:0] rem;
  logic [DEN_BITS-1:0] dmag;
  logic                neg;
  logic [CNT_BITS-1:0] cnt;
  logic [DEN_BITS:0]   trial;
  logic [DEN_BITS:0]   diff;
  logic                ge;

  assign numer_u = numer;
  assign denom_u = denom;
  assign nmag    = numer[NUM_BITS-1] ? (~numer_u + 1'b1) : numer_u;
  assign dmag_in = denom[DEN_BITS-1] ? (~denom_u + 1'b1) : denom_u;

  assign trial = {rem, quo[NUM_BITS-1]};
  assign diff  = trial - {1'b0, dmag};
  assign ge    = (trial >= {1'b0, dmag});

  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      cnt     <= '0;
    end else if (start) begin
      running <= 1'b1;
      cnt     <= CNT_BITS'(NUM_BITS);
    end else if (running) begin
      cnt <= cnt - 1'b1;
      if (cnt == CNT_BITS'(1)) begin
        running <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo  <= nmag;
      rem  <= '0;
      dmag <= dmag_in;
      neg  <= numer[NUM_BITS-1] ^ denom[DEN_BITS-1];
    end else if (running) begin
      rem <= ge ? diff[DEN_BITS-1:0] : trial[DEN_BITS-1:0];
      quo <= {quo[NUM_BITS-2:0], ge};
    end
  end

  assign quot = neg ? -$signed(quo) : $signed(quo);

  a_no_restart : assert property (@(posedge clk) disable iff (rst) start |-> !running)
    else $error("divider restarted while a division is in flight");

endmodule

[hdl/tlr_datapath.sv]
// Datapath: latched line operands, center and brush offset registers, disc test,
// address generation and the result register. Depends on tlr_pkg, tlr_divider, interfaces.
module tlr_datapath #(
  parameter int COORD_BITS  = tlr_pkg::COORD_BITS_DEF,
  parameter int FRAME_WIDTH = tlr_pkg::FRAME_WIDTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  tlr_pkg::tlr_cmd_t             cmd,
  output tlr_pkg::tlr_sts_t             sts,
  input  logic [tlr_pkg::ADDR_BITS-1:0] frame_base,
  tlr_in_if.sink                        req,
  tlr_out_if.source                     rsp
);
  import tlr_pkg::*;

  localparam int DB      = COORD_BITS + 1;
  localparam int NW      = 2 * DB;
  localparam int SQ_BITS = 2 * DISC_BITS;

  logic signed [COORD_BITS-1:0] xs, ys, xe, ye;
  logic signed [COORD_BITS-1:0] major_pos, minor_pos;
  logic signed [COORD_BITS-1:0] ms, me, ns, ne, cx, cy;
  logic [SIZE_BITS-1:0]         size;
  logic [COLOR_BITS-1:0]        color;
  logic                         x_major, busy, res_done, out_valid;
  logic signed [DISC_BITS-1:0]  di, dj, lim, neg_lim;
  logic signed [DB-1:0]         dx, dy, dmin, doff, dmaj, px, py;
  logic [DB-1:0]                adx, ady;
  logic                         x_wins;
  logic signed [NW-1:0]         prod, quot;
  logic                         div_running;
  logic [2*SIZE_BITS-1:0]       size_sq, thr;
  logic signed [SQ_BITS-1:0]    di_w, dj_w, isq, jsq, thr_w;
  logic [ADDR_BITS-1:0]         addr_calc;
  logic                         out_kind;
  logic [ADDR_BITS-1:0]         out_addr;
  logic [COLOR_BITS-1:0]        out_color;

  // major/minor view of the latched endpoints
  assign ms = x_major ? xs : ys;
  assign me = x_major ? xe : ye;
  assign ns = x_major ? ys : xs;
  assign ne = x_major ? ye : xe;
  assign cx = x_major ? major_pos : minor_pos;
  assign cy = x_major ? minor_pos : major_pos;

  // dx*dx > dy*dy is the same as |dx| > |dy|
  assign dx     = DB'(xs) - DB'(xe);
  assign dy     = DB'(ys) - DB'(ye);
  assign adx    = dx[DB-1] ? DB'(-dx) : DB'(dx);
  assign ady    = dy[DB-1] ? DB'(-dy) : DB'(dy);
  assign x_wins = (adx > ady);

  assign dmin = DB'(ne) - DB'(ns);
  assign doff = DB'(major_pos) - DB'(ms);

  // disc membership
  assign lim     = DISC_BITS'(size[SIZE_BITS-1:1]);
  assign neg_lim = -lim;
  assign size_sq = size * size;
  assign thr     = size_sq >> THR_SHIFT;
  assign thr_w   = SQ_BITS'(thr);
  assign di_w    = SQ_BITS'(di);
  assign dj_w    = SQ_BITS'(dj);
  assign isq     = di_w * di_w;
  assign jsq     = dj_w * dj_w;

  assign addr_calc = frame_base + ADDR_BITS'(px) + ADDR_BITS'(py) * ADDR_BITS'(FRAME_WIDTH);

  tlr_divider #(
    .NUM_BITS (NW),
    .DEN_BITS (DB)
  ) u_div (
    .clk     (clk),
    .rst     (rst),
    .start   (cmd.div_go),
    .numer   (prod),
    .denom   (dmaj),
    .running (div_running),
    .quot    (quot)
  );

  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      xs    <= req.x_start;
      ys    <= req.y_start;
      xe    <= req.x_end;
      ye    <= req.y_end;
      size  <= req.brush_size;
      color <= req.pen_color;
    end
    if (cmd.setup) begin
      x_major   <= x_wins;
      major_pos <= x_wins ? xs : ys;
    end
    if (cmd.mul) begin
      prod <= NW'(dmin) * NW'(doff);
      dmaj <= DB'(me) - DB'(ms);
    end
    if (cmd.place) begin
      minor_pos <= (dmaj == '0) ? ns : ns + quot[COORD_BITS-1:0];
      di        <= neg_lim;
      dj        <= neg_lim;
    end
    if (cmd.step_major) begin
      major_pos <= (ms < me) ? major_pos + 1'b1 : major_pos - 1'b1;
    end
    if (cmd.next_row) begin
      di <= di + 1'b1;
      dj <= neg_lim;
    end
    if (cmd.next_col) begin
      dj <= dj + 1'b1;
      px <= DB'(cx) + DB'(di);
      py <= DB'(cy) + DB'(dj);
    end
    if (cmd.next_col) begin
      res_done <= 1'b0;
    end else if (cmd.finish) begin
      res_done <= 1'b1;
    end
    if (cmd.load_out) begin
      out_kind  <= res_done ? KIND_DONE : KIND_PIXEL;
      out_addr  <= res_done ? '0 : addr_calc;
      out_color <= res_done ? '0 : color;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy      <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (cmd.latch) begin
        busy <= 1'b1;
      end else if (cmd.finish) begin
        busy <= 1'b0;
      end
      if (cmd.load_out) begin
        out_valid <= 1'b1;
      end else if (rsp.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  assign req.ready       = cmd.take_in;
  assign rsp.valid       = out_valid;
  assign rsp.kind        = out_kind;
  assign rsp.address     = out_addr;
  assign rsp.pixel_color = out_color;

  assign sts.in_valid    = req.valid;
  assign sts.in_mode     = req.mode;
  assign sts.busy        = busy;
  assign sts.at_end      = (major_pos == me);
  assign sts.i_done      = (di >= lim);
  assign sts.j_done      = (dj >= lim);
  assign sts.in_disc     = ((isq + jsq) <= thr_w);
  assign sts.div_running = div_running;
  assign sts.out_free    = !out_valid || rsp.ready;

  a_no_overwrite : assert property (@(posedge clk) disable iff (rst)
    cmd.load_out |-> (!out_valid || rsp.ready))
    else $error("result register overwritten before it was taken");

endmodule

[hdl/tlr_ctrl.sv]
// Controller state machine: sequences setup, center division, disc scan and result hand-off.
// Depends on tlr_pkg for the command and status structs.
module tlr_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  tlr_pkg::tlr_sts_t sts,
  output tlr_pkg::tlr_cmd_t cmd
);
  import tlr_pkg::*;

  typedef enum logic [7:0] {
    S_IDLE  = 8'b0000_0001,
    S_SETUP = 8'b0000_0010,
    S_MUL   = 8'b0000_0100,
    S_DIVGO = 8'b0000_1000,
    S_DIV   = 8'b0001_0000,
    S_PLACE = 8'b0010_0000,
    S_SCAN  = 8'b0100_0000,
    S_EMIT  = 8'b1000_0000
  } state_t;

  state_t state, state_next;
  logic   resume, resume_next;

  always_comb begin
    cmd         = '0;
    state_next  = state;
    resume_next = resume;
    case (state)
      S_IDLE: begin
        cmd.take_in = 1'b1;
        if (sts.in_valid) begin
          if (sts.in_mode == MODE_START) begin
            cmd.latch   = 1'b1;
            resume_next = 1'b0;
            state_next  = S_SETUP;
          end else begin
            state_next = S_SCAN;
          end
        end
      end
      S_SETUP: begin
        cmd.setup  = 1'b1;
        state_next = S_MUL;
      end
      S_MUL: begin
        cmd.mul    = 1'b1;
        state_next = S_DIVGO;
      end
      S_DIVGO: begin
        cmd.div_go = 1'b1;
        state_next = S_DIV;
      end
      S_DIV: begin
        if (!sts.div_running) begin
          state_next = S_PLACE;
        end
      end
      S_PLACE: begin
        cmd.place  = 1'b1;
        state_next = resume ? S_SCAN : S_IDLE;
      end
      S_SCAN: begin
        if (!sts.busy || sts.at_end) begin
          cmd.finish = 1'b1;
          state_next = S_EMIT;
        end else if (sts.i_done) begin
          cmd.step_major = 1'b1;
          resume_next    = 1'b1;
          state_next     = S_MUL;
        end else if (sts.j_done) begin
          cmd.next_row = 1'b1;
        end else begin
          cmd.next_col = 1'b1;
          if (sts.in_disc) begin
            state_next = S_EMIT;
          end
        end
      end
      S_EMIT: begin
        if (sts.out_free) begin
          cmd.load_out = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= S_IDLE;
      resume <= 1'b0;
    end else begin
      state  <= state_next;
      resume <= resume_next;
    end
  end

  a_idle_quiet : assert property (@(posedge clk) disable iff (rst)
    cmd.take_in |-> !sts.div_running)
    else $error("command taken while the divider is still busy");

  a_emit_holds : assert property (@(posedge clk) disable iff (rst)
    (state == S_EMIT) && !sts.out_free |=> (state == S_EMIT))
    else $error("result dropped while the output was stalled");

endmodule

[hdl/thick_line_rasterizer.sv]
// Top level of the thick line rasterizer: APB register, controller and datapath.
// Depends on tlr_pkg, tlr_in_if, tlr_out_if, tlr_ctrl, tlr_datapath.
//
//   channel  dir  handshake        word
//   -------  ---  ---------------  ------------------------------------------------
//   req      in   valid/ready      mode, x_start, y_start, x_end, y_end,
//                                  brush_size, pen_color
//   rsp      out  valid/ready      kind, address, pixel_color
//   apb      in   psel/penable     frame_base at byte address 0 (pready always high)
//
// Words are taken one at a time; req ready is high only while the controller idles.
// Start word: setup, multiply, divider start, the bit-serial divide and place set the first
//   center. Step word: the scan tests an offset, wraps a row or checks for the end, and each
//   new center reruns multiply, divider start, divide and place. A waiting result lets the
//   next word in; a stalled rsp holds emit only when a second result is ready. rst (sync)
//   idles all and reloads frame_base.
module thick_line_rasterizer #(
  parameter int COORD_BITS  = tlr_pkg::COORD_BITS_DEF,
  parameter int FRAME_WIDTH = tlr_pkg::FRAME_WIDTH_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  tlr_in_if.sink                            req,
  tlr_out_if.source                         rsp,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [tlr_pkg::APB_ADDR_BITS-1:0] paddr,
  input  logic [tlr_pkg::APB_DATA_BITS-1:0] pwdata,
  output logic [tlr_pkg::APB_DATA_BITS-1:0] prdata,
  output logic                              pready
);
  import tlr_pkg::*;

  logic [ADDR_BITS-1:0] frame_base;
  logic                 reg_sel;
  tlr_cmd_t             cmd;
  tlr_sts_t             sts;

  // register index sits in the top address bit; low bits are the byte lane
  assign reg_sel = (paddr[APB_ADDR_BITS-1] == REG_FRAME_BASE);
  assign pready  = 1'b1;
  assign prdata  = reg_sel ? frame_base : '0;

  // write on the access cycle; anything beyond the register list is dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      frame_base <= FRAME_BASE_RST;
    end else if (psel && penable && pwrite && pready && reg_sel) begin
      frame_base <= pwdata;
    end
  end

  tlr_ctrl u_ctrl (
    .clk (clk),
    .rst (rst),
    .sts (sts),
    .cmd (cmd)
  );

  tlr_datapath #(
    .COORD_BITS  (COORD_BITS),
    .FRAME_WIDTH (FRAME_WIDTH)
  ) u_dp (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .sts        (sts),
    .frame_base (frame_base),
    .req        (req),
    .rsp        (rsp)
  );

endmodule
